// ===== hdl/sapp_pkg.sv =====
// ----------------------------------------------------------------------------
// sapp_pkg: SAP announcement parser shared types and constants
// Phase and code enums, result item layout and the MIME text table.
// ----------------------------------------------------------------------------
package sapp_pkg;

  typedef enum logic [3:0] {
    PH_H0,
    PH_H1,
    PH_H2,
    PH_H3,
    PH_ADDR,
    PH_AUTH,
    PH_MIME,
    PH_APP,
    PH_V,
    PH_VEQ,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_ADDRESS = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_VERSION    = 3'd2,
    ST_ENCRYPTED  = 3'd3,
    ST_COMPRESSED = 3'd4,
    ST_MIME       = 3'd5,
    ST_TRUNCATED  = 3'd6
  } status_t;

  // flag byte bits
  localparam int FLAG_VERSION_BIT    = 5;
  localparam int FLAG_IPV6_BIT       = 4;
  localparam int FLAG_DELETE_BIT     = 2;
  localparam int FLAG_ENCRYPTED_BIT  = 1;
  localparam int FLAG_COMPRESSED_BIT = 0;

  localparam logic [4:0] ADDR_BYTES_IPV4 = 5'd4;
  localparam logic [4:0] ADDR_BYTES_IPV6 = 5'd16;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_A   = 8'h61;
  localparam logic [7:0] CHAR_V   = 8'h76;
  localparam logic [7:0] CHAR_EQ  = 8'h3d;
  localparam logic [7:0] CHAR_0   = 8'h30;

  localparam int ITEMS_PER_BYTE = 4;
  localparam int TDATA_BITS     = 32;

  // packed with data_byte in the low bits
  typedef struct packed {
    status_t     status;
    logic        source_is_ipv6;
    logic [15:0] id_hash;
    logic        message_is_delete;
    logic [7:0]  data_byte;
  } item_data_t;

  typedef struct packed {
    logic       last;
    kind_t      kind;
    item_data_t data;
  } item_t;

  typedef struct packed {
    logic [2:0]                     count;
    item_t [ITEMS_PER_BYTE-1:0]     item;
  } result_bundle_t;

  // "application/sdp" followed by NUL
  function automatic logic [7:0] mime_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h61;
      4'd1:    c = 8'h70;
      4'd2:    c = 8'h70;
      4'd3:    c = 8'h6c;
      4'd4:    c = 8'h69;
      4'd5:    c = 8'h63;
      4'd6:    c = 8'h61;
      4'd7:    c = 8'h74;
      4'd8:    c = 8'h69;
      4'd9:    c = 8'h6f;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h2f;
      4'd12:   c = 8'h73;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h70;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/sapp_parser.sv =====
// ----------------------------------------------------------------------------
// sapp_parser: SAP header state machine
// Updates the parse state on each accepted byte and emits up to four items.
// ----------------------------------------------------------------------------
module sapp_parser import sapp_pkg::*; #(
  parameter int MIN_PACKET_BYTES = 12,
  parameter int COUNT_BITS       = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     packet_byte,
  input  logic           end_of_packet,
  output result_bundle_t bundle
);

  localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(MIN_PACKET_BYTES);

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [4:0]            address_left, address_left_next;
  logic [9:0]            auth_left, auth_left_next;
  logic [3:0]            mime_index, mime_index_next;
  status_t               error_code, error_code_next;
  logic [7:0]            flag_byte, flag_byte_next;
  logic [7:0]            hash_high, hash_high_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_H0;
      byte_count   <= '0;
      address_left <= '0;
      auth_left    <= '0;
      mime_index   <= '0;
      error_code   <= ST_OK;
      flag_byte    <= '0;
      hash_high    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      address_left <= address_left_next;
      auth_left    <= auth_left_next;
      mime_index   <= mime_index_next;
      error_code   <= error_code_next;
      flag_byte    <= flag_byte_next;
      hash_high    <= hash_high_next;
    end
  end

  always_comb begin
    item_t      it;
    logic [2:0] n;
    logic [4:0] addr_dec;
    logic [9:0] auth_dec;
    status_t    st;

    phase_next        = phase;
    address_left_next = address_left;
    auth_left_next    = auth_left;
    mime_index_next   = mime_index;
    error_code_next   = error_code;
    flag_byte_next    = flag_byte;
    hash_high_next    = hash_high;
    byte_count_next   = (byte_count != '1) ? byte_count + 1'b1 : byte_count;
    bundle            = '0;
    n                 = '0;
    addr_dec          = address_left - {4'd0, address_left != 5'd0};
    auth_dec          = auth_left - {9'd0, auth_left != 10'd0};
    st                = ST_OK;
    it                = '0;

    case (phase)
      PH_H0: begin
        flag_byte_next = packet_byte;
        if (!packet_byte[FLAG_VERSION_BIT]) begin
          error_code_next = ST_VERSION;
          phase_next      = PH_DRAIN;
        end else if (packet_byte[FLAG_ENCRYPTED_BIT]) begin
          error_code_next = ST_ENCRYPTED;
          phase_next      = PH_DRAIN;
        end else if (packet_byte[FLAG_COMPRESSED_BIT]) begin
          error_code_next = ST_COMPRESSED;
          phase_next      = PH_DRAIN;
        end else begin
          phase_next = PH_H1;
        end
      end
      PH_H1: begin
        auth_left_next = {packet_byte, 2'b00};
        phase_next     = PH_H2;
      end
      PH_H2: begin
        hash_high_next = packet_byte;
        phase_next     = PH_H3;
      end
      PH_H3: begin
        it                        = '0;
        it.kind                   = KIND_HEADER;
        it.data.message_is_delete = flag_byte[FLAG_DELETE_BIT];
        it.data.id_hash           = {hash_high, packet_byte};
        it.data.source_is_ipv6    = flag_byte[FLAG_IPV6_BIT];
        bundle.item[0]            = it;
        n                         = 3'd1;
        address_left_next = flag_byte[FLAG_IPV6_BIT] ? ADDR_BYTES_IPV6 : ADDR_BYTES_IPV4;
        phase_next        = PH_ADDR;
      end
      PH_ADDR: begin
        it                = '0;
        it.kind           = KIND_ADDRESS;
        it.data.data_byte = packet_byte;
        bundle.item[0]    = it;
        n                 = 3'd1;
        address_left_next = addr_dec;
        if (addr_dec == 5'd0) begin
          phase_next = (auth_left != 10'd0) ? PH_AUTH : PH_MIME;
        end
      end
      PH_AUTH: begin
        auth_left_next = auth_dec;
        if (auth_dec == 10'd0) begin
          phase_next = PH_MIME;
        end
      end
      PH_MIME: begin
        if (packet_byte == CHAR_NUL) begin
          phase_next = PH_PAYLOAD;
        end else if (packet_byte == CHAR_A) begin
          mime_index_next = 4'd1;
          phase_next      = PH_APP;
        end else if (packet_byte == CHAR_V) begin
          phase_next = PH_V;
        end else begin
          error_code_next = ST_MIME;
          phase_next      = PH_DRAIN;
        end
      end
      PH_APP: begin
        if (packet_byte != mime_char(mime_index)) begin
          error_code_next = ST_MIME;
          phase_next      = PH_DRAIN;
        end else if (mime_index == 4'd15) begin
          phase_next = PH_PAYLOAD;
        end else begin
          mime_index_next = mime_index + 4'd1;
        end
      end
      PH_V: begin
        if (packet_byte == CHAR_EQ) begin
          phase_next = PH_VEQ;
        end else begin
          error_code_next = ST_MIME;
          phase_next      = PH_DRAIN;
        end
      end
      PH_VEQ: begin
        if (packet_byte == CHAR_0) begin
          // release the held "v=" ahead of the '0'
          it                = '0;
          it.kind           = KIND_PAYLOAD;
          it.data.data_byte = CHAR_V;
          bundle.item[0]    = it;
          it.data.data_byte = CHAR_EQ;
          bundle.item[1]    = it;
          it.data.data_byte = packet_byte;
          bundle.item[2]    = it;
          n                 = 3'd3;
          phase_next        = PH_PAYLOAD;
        end else begin
          error_code_next = ST_MIME;
          phase_next      = PH_DRAIN;
        end
      end
      PH_PAYLOAD: begin
        it                = '0;
        it.kind           = KIND_PAYLOAD;
        it.data.data_byte = packet_byte;
        bundle.item[0]    = it;
        n                 = 3'd1;
      end
      default: begin
      end
    endcase

    if (end_of_packet) begin
      if (byte_count_next < MIN_COUNT) begin
        st = ST_SHORT;
      end else if (error_code_next != ST_OK) begin
        st = error_code_next;
      end else if (phase_next != PH_PAYLOAD) begin
        st = ST_TRUNCATED;
      end else begin
        st = ST_OK;
      end
      it                   = '0;
      it.kind              = KIND_STATUS;
      it.last              = 1'b1;
      it.data.status       = st;
      bundle.item[n[1:0]]  = it;
      n                    = n + 3'd1;
      // back to the idle header state for the next packet
      phase_next        = PH_H0;
      byte_count_next   = '0;
      address_left_next = '0;
      auth_left_next    = '0;
      mime_index_next   = '0;
      error_code_next   = ST_OK;
      flag_byte_next    = '0;
      hash_high_next    = '0;
    end

    bundle.count = accept ? n : 3'd0;
  end

  assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_packet) |=> (phase == PH_H0 && byte_count == '0))
    else $error("parser did not return to idle after packet end");

  assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_OK) |-> (phase == PH_DRAIN))
    else $error("error recorded outside drain phase");

  assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_packet) |-> (bundle.count != 3'd0 &&
      bundle.item[bundle.count[1:0] - 2'd1].last))
    else $error("packet end without closing status item");

endmodule

// ===== hdl/sapp_queue.sv =====
// ----------------------------------------------------------------------------
// sapp_queue: result item queue
// Shift queue that takes up to four items per cycle and hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sapp_queue import sapp_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  result_bundle_t bundle,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output item_t          out_item
);

  localparam int CW = $clog2(DEPTH + 1);

  item_t [DEPTH-1:0] entries, entries_next;
  logic  [CW-1:0]    count, count_next;
  logic              pop;
  logic  [CW-1:0]    base;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_item  = entries[0];
  // room for a full burst from one byte
  assign room      = count <= CW'(DEPTH - ITEMS_PER_BYTE);
  assign base       = count - CW'(pop);
  assign count_next = base + CW'(bundle.count);

  always_comb begin
    logic [CW-1:0] k;
    for (int j = 0; j < DEPTH; j++) begin
      if (pop && j < DEPTH - 1) begin
        entries_next[j] = entries[(j < DEPTH - 1) ? j + 1 : j];
      end else begin
        entries_next[j] = entries[j];
      end
      k = CW'(j) - base;
      if (CW'(j) >= base && CW'(j) < count_next) begin
        entries_next[j] = bundle.item[k[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    entries <= entries_next;
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    (bundle.count != 3'd0) |-> room)
    else $error("items pushed without room");

  assert property (@(posedge clk) disable iff (rst)
    (pop && bundle.count == 3'd0) |=> (count == $past(count) - CW'(1)))
    else $error("queue count did not follow a lone pop");

endmodule

// ===== hdl/sap_announcement_parser.sv =====
// ----------------------------------------------------------------------------
// sap_announcement_parser: SAP announcement header parser
// Parses a SAP packet byte stream into header, address, payload and status.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                        tuser  tlast
// s_axis    in   packet_byte                  -      end_of_packet
// m_axis    out  data_byte..status (29 bits)  kind   last
//
// One packet byte is taken per cycle while the result queue has room for a
// full burst; the byte is parsed in the cycle it is accepted and its items
// are registered into the queue, whose head drives m_axis.
// A byte yields up to four items ("v=0" release plus packet end status);
// a ready m_axis drains one item per cycle, so only bursts slow intake.
// rst is synchronous and empties the queue and returns to the first header
// byte. A stalled m_axis holds the queue head; intake waits for burst room.
// ----------------------------------------------------------------------------
module sap_announcement_parser import sapp_pkg::*; #(
  parameter int MIN_PACKET_BYTES = 12,
  parameter int COUNT_BITS       = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] packet_byte
  input  logic                  s_axis_tlast,   // end_of_packet
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] data_byte, [8] message_is_delete, [24:9] id_hash,
  // [25] source_is_ipv6, [28:26] status, [31:29] zero
  output logic [TDATA_BITS-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,   // [1:0] kind
  output logic                  m_axis_tlast    // last
);

  result_bundle_t bundle;
  item_t          head;
  logic           accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  sapp_parser #(
    .MIN_PACKET_BYTES (MIN_PACKET_BYTES),
    .COUNT_BITS       (COUNT_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .packet_byte   (s_axis_tdata),
    .end_of_packet (s_axis_tlast),
    .bundle        (bundle)
  );

  sapp_queue #(
    .DEPTH (8)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .bundle    (bundle),
    .room      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (head)
  );

  assign m_axis_tdata = {(TDATA_BITS - $bits(item_data_t))'(0), head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
